// ===== design/hhr_pkg.sv =====
// ----------------------------------------------------------------------------
// hhr_pkg
// Types and constants shared by the handle hash registry modules.
// ----------------------------------------------------------------------------
package hhr_pkg;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TAG_EMPTY = 2'd0,
		TAG_LIVE  = 2'd1,
		TAG_TOMB  = 2'd2
	} tag_t;

	typedef struct packed {
		tag_t        tag;
		logic [3:0]  htype;
		logic [63:0] key;
	} entry_t;

	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int unsigned MIX_SHIFT = 33;
	localparam int unsigned SLOT_OUT_W = 6;
	localparam int unsigned LIVE_OUT_W = 7;

endpackage

// ===== design/hhr_ram.sv =====
// ----------------------------------------------------------------------------
// hhr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hhr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/hhr_hash.sv =====
// ----------------------------------------------------------------------------
// hhr_hash
// Murmur finalizer over a shared 32x32 multiplier, then reduction to a slot.
// ----------------------------------------------------------------------------
module hhr_hash #(
	parameter int SLOTS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [63:0]              key,
	output logic                     done,
	output logic [$clog2(SLOTS)-1:0] slot
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam bit IS_POW2 = (SLOTS == (1 << IDX_W));
	localparam int FOLD_W = 30;

	function automatic logic [IDX_W-1:0] pow2_mod(input int e);
		int r;
		r = 1;
		for (int i = 0; i < e; i++) begin
			r = (r * 2) % SLOTS;
		end
		return IDX_W'(r);
	endfunction

	localparam logic [IDX_W-1:0] RES_16 = pow2_mod(16);
	localparam logic [IDX_W-1:0] RES_32 = pow2_mod(32);
	localparam logic [IDX_W-1:0] RES_48 = pow2_mod(48);
	localparam logic [32:0]      RECIP  = 33'h100000000 / 33'(SLOTS);

	typedef enum logic [2:0] {
		H_IDLE,
		H_XOR,
		H_MUL,
		H_MOD
	} hstate_t;

	hstate_t           state_q;
	logic [63:0]       v_q;
	logic [63:0]       acc_q;
	logic [63:0]       prod_q;
	logic [1:0]        step_q;
	logic [1:0]        round_q;
	logic [FOLD_W-1:0] fold_q;
	logic [FOLD_W-1:0] quot_q;
	logic [IDX_W:0]    rem_q;

	logic [63:0]       mconst;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       mul_p;
	logic [FOLD_W-1:0] fold_sum;
	logic [FOLD_W-1:0] fold_diff;

	assign mconst = round_q[0] ? hhr_pkg::MIX_C2 : hhr_pkg::MIX_C1;

	always_comb begin
		if (state_q == H_MOD) begin
			mul_a = 32'(fold_q);
			mul_b = RECIP[31:0];
		end else begin
			unique case (step_q)
				2'd1: begin
					mul_a = v_q[63:32];
					mul_b = mconst[31:0];
				end
				2'd2: begin
					mul_a = v_q[31:0];
					mul_b = mconst[63:32];
				end
				default: begin
					mul_a = v_q[31:0];
					mul_b = mconst[31:0];
				end
			endcase
		end
	end

	assign mul_p = mul_a * mul_b;

	// Each 16-bit chunk of the hash is weighted by its power of two modulo SLOTS.
	assign fold_sum = FOLD_W'(v_q[15:0])
		+ FOLD_W'(v_q[31:16]) * FOLD_W'(RES_16)
		+ FOLD_W'(v_q[47:32]) * FOLD_W'(RES_32)
		+ FOLD_W'(v_q[63:48]) * FOLD_W'(RES_48);
	assign fold_diff = fold_q - quot_q * FOLD_W'(SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done    <= 1'b0;
			step_q  <= 2'd0;
			round_q <= 2'd0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						v_q     <= key;
						round_q <= 2'd0;
						state_q <= H_XOR;
					end
				end
				H_XOR: begin
					v_q    <= v_q ^ (v_q >> hhr_pkg::MIX_SHIFT);
					step_q <= 2'd0;
					if (round_q == 2'd2) begin
						state_q <= H_MOD;
					end else begin
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					step_q <= step_q + 2'd1;
					unique case (step_q)
						2'd0: begin
							prod_q <= mul_p;
						end
						2'd1: begin
							acc_q  <= prod_q;
							prod_q <= mul_p;
						end
						2'd2: begin
							acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
							prod_q       <= mul_p;
						end
						default: begin
							v_q     <= {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
							round_q <= round_q + 2'd1;
							state_q <= H_XOR;
						end
					endcase
				end
				H_MOD: begin
					if (IS_POW2) begin
						slot    <= v_q[IDX_W-1:0];
						done    <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						step_q <= step_q + 2'd1;
						unique case (step_q)
							2'd0: begin
								fold_q <= fold_sum;
							end
							2'd1: begin
								quot_q <= mul_p[FOLD_W+31:32];
							end
							2'd2: begin
								rem_q <= fold_diff[IDX_W:0];
							end
							default: begin
								if (rem_q >= (IDX_W+1)'(SLOTS)) begin
									slot <= IDX_W'(rem_q - (IDX_W+1)'(SLOTS));
								end else begin
									slot <= rem_q[IDX_W-1:0];
								end
								done    <= 1'b1;
								state_q <= H_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= H_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/handle_hash_registry_core.sv =====
// ----------------------------------------------------------------------------
// handle_hash_registry_core
// Open-addressing hash table of 64-bit handle keys with linear probing.
// ----------------------------------------------------------------------------
// One word is handled at a time. The key is hashed with the murmur finalizer
// on one shared 32x32 multiplier, reduced to a slot (by its low bits when
// SLOTS is a power of two, by a fold and a reciprocal multiply otherwise) and
// handed to the probe. The table memory is then probed with a read state and
// a check state per slot visited, and an action state and a done state give
// the result word. A clear sweeps every slot of the memory to empty and then
// gives its result, and after reset the same sweep runs before the first word
// is taken. Reserved keys skip the hash and the probe. The next word is taken
// once the result word is issued, which waits while the output is stalled.
module handle_hash_registry_core #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] key,
	input  logic [3:0]  handle_type,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  slot_index,
	output logic [3:0]  type_out,
	output logic [6:0]  live_count
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int ENT_W = $bits(hhr_pkg::entry_t);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_HASH,
		S_RD,
		S_CK,
		S_ACT,
		S_DONE
	} state_t;

	state_t                  state_q;
	hhr_pkg::action_t        act_q;
	logic [63:0]             key_q;
	logic [3:0]              type_q;
	logic                    clr_reply_q;
	logic [IDX_W-1:0]        clr_q;
	logic [IDX_W-1:0]        pos_q;
	logic [CNT_W-1:0]        n_q;
	logic                    tomb_v_q;
	logic [IDX_W-1:0]        tomb_q;
	logic                    found_q;
	logic                    hit_q;
	logic [IDX_W-1:0]        s_q;
	logic [3:0]              stype_q;
	logic [CNT_W-1:0]        cnt_q;
	hhr_pkg::status_t        res_status_q;
	logic [IDX_W-1:0]        res_slot_q;
	logic [3:0]              res_type_q;

	logic                    hash_start;
	logic                    hash_done;
	logic [IDX_W-1:0]        hash_slot;
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	hhr_pkg::entry_t         ram_wdata;
	hhr_pkg::entry_t         ram_rdata;
	logic [ENT_W-1:0]        ram_rbits;
	logic [IDX_W-1:0]        pos_next;

	assign in_stall   = (state_q != S_IDLE);
	assign hash_start = (state_q == S_IDLE) && in_valid
		&& (hhr_pkg::action_t'(action) != hhr_pkg::ACT_CLEAR)
		&& (key != 64'd0) && (key != '1);
	assign ram_rdata  = hhr_pkg::entry_t'(ram_rbits);
	assign pos_next   = (pos_q == IDX_W'(SLOTS - 1)) ? '0 : pos_q + 1'b1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = s_q;
		ram_wdata = '{tag: hhr_pkg::TAG_LIVE, htype: type_q, key: key_q};
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '{tag: hhr_pkg::TAG_EMPTY, htype: type_q, key: key_q};
		end else if (state_q == S_ACT) begin
			if (act_q == hhr_pkg::ACT_INSERT) begin
				ram_we = found_q;
			end else if (act_q == hhr_pkg::ACT_DELETE) begin
				ram_we    = hit_q;
				ram_wdata = '{tag: hhr_pkg::TAG_TOMB, htype: stype_q, key: key_q};
			end
		end
	end

	hhr_hash #(
		.SLOTS(SLOTS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (key),
		.done  (hash_done),
		.slot  (hash_slot)
	);

	hhr_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(pos_q),
		.rdata(ram_rbits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_reply_q <= 1'b0;
			cnt_q       <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						clr_q <= '0;
						cnt_q <= '0;
						if (clr_reply_q) begin
							res_status_q <= hhr_pkg::ST_OK;
							res_slot_q   <= '0;
							res_type_q   <= 4'd0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						act_q       <= hhr_pkg::action_t'(action);
						key_q       <= key;
						type_q      <= handle_type;
						clr_reply_q <= 1'b1;
						if (hhr_pkg::action_t'(action) == hhr_pkg::ACT_CLEAR) begin
							state_q <= S_CLR;
						end else if (hash_start) begin
							state_q <= S_HASH;
						end else begin
							res_status_q <= hhr_pkg::ST_INVALID;
							res_slot_q   <= '0;
							res_type_q   <= 4'd0;
							state_q      <= S_DONE;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						pos_q    <= hash_slot;
						n_q      <= '0;
						tomb_v_q <= 1'b0;
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CK;
				end
				S_CK: begin
					priority if (ram_rdata.tag == hhr_pkg::TAG_EMPTY) begin
						found_q <= 1'b1;
						hit_q   <= 1'b0;
						s_q     <= tomb_v_q ? tomb_q : pos_q;
						state_q <= S_ACT;
					end else if (ram_rdata.tag == hhr_pkg::TAG_LIVE
						&& ram_rdata.key == key_q) begin
						found_q <= 1'b1;
						hit_q   <= 1'b1;
						s_q     <= pos_q;
						stype_q <= ram_rdata.htype;
						state_q <= S_ACT;
					end else begin
						if (ram_rdata.tag == hhr_pkg::TAG_TOMB && !tomb_v_q) begin
							tomb_v_q <= 1'b1;
							tomb_q   <= pos_q;
						end
						if (n_q == CNT_W'(SLOTS - 1)) begin
							found_q <= tomb_v_q || (ram_rdata.tag == hhr_pkg::TAG_TOMB);
							hit_q   <= 1'b0;
							s_q     <= tomb_v_q ? tomb_q : pos_q;
							state_q <= S_ACT;
						end else begin
							n_q     <= n_q + 1'b1;
							pos_q   <= pos_next;
							state_q <= S_RD;
						end
					end
				end
				S_ACT: begin
					state_q      <= S_DONE;
					res_status_q <= hhr_pkg::ST_OK;
					res_slot_q   <= s_q;
					if (act_q == hhr_pkg::ACT_INSERT) begin
						res_type_q <= type_q;
						if (!found_q) begin
							res_status_q <= hhr_pkg::ST_FULL;
							res_slot_q   <= '0;
							res_type_q   <= 4'd0;
						end else if (!hit_q) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						res_type_q <= stype_q;
						if (!hit_q) begin
							res_status_q <= hhr_pkg::ST_NOT_FOUND;
							res_slot_q   <= '0;
							res_type_q   <= 4'd0;
						end else if (act_q == hhr_pkg::ACT_DELETE) begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid   <= 1'b1;
						status      <= res_status_q;
						slot_index  <= hhr_pkg::SLOT_OUT_W'(res_slot_q);
						type_out    <= res_type_q;
						live_count  <= hhr_pkg::LIVE_OUT_W'(cnt_q);
						clr_reply_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for handle_hash_registry_core. Words are driven at
// the falling edge and results are sampled at the rising edge. A directed
// table walks the reserved keys, every action, duplicate inserts, a full
// table and clears. A random phase follows with a small working set of keys,
// so that hits, misses, tombstones and full-table cases are frequent. Each
// result is compared with a behavioral hash table model in this file.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		hhr_pkg::action_t act;
		logic [63:0]      k;
		logic [3:0]       ht;
		logic             known;
		hhr_pkg::status_t st;
		logic [5:0]       si;
		logic [3:0]       to;
		logic [6:0]       lc;
	} row_t;

	typedef struct packed {
		hhr_pkg::status_t st;
		logic [5:0]       si;
		logic [3:0]       to;
		logic [6:0]       lc;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = '0;
	logic [63:0] key = '0;
	logic [3:0]  handle_type = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [5:0]  slot_index;
	logic [3:0]  type_out;
	logic [6:0]  live_count;

	logic [63:0]   tbl_key [64];
	hhr_pkg::tag_t tbl_tag [64];
	logic [3:0]    tbl_type [64];
	int            live_n;
	answer_t       pending [$];
	int            errors = 0;
	int            cycle = 0;
	int            send_idle = 0;
	int            recv_stall = 0;
	logic [63:0]   key_pool [16];

	handle_hash_registry_core #(.SLOTS(64)) i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 3000000) begin
			$display("** handle_hash_registry_core: FAILED **");
			$finish;
		end
	end

	function automatic logic [63:0] murmur_mix(input logic [63:0] v);
		v = v ^ (v >> 33);
		v = v * 64'hff51afd7ed558ccd;
		v = v ^ (v >> 33);
		v = v * 64'hc4ceb9fe1a85ec53;
		v = v ^ (v >> 33);
		return v;
	endfunction

	function automatic int find_slot(input logic [63:0] k);
		int pos;
		int tomb;
		pos = int'(murmur_mix(k) % 64);
		tomb = -1;
		for (int n = 0; n < 64; n++) begin
			if (tbl_tag[pos] == hhr_pkg::TAG_EMPTY) return (tomb >= 0) ? tomb : pos;
			if (tbl_tag[pos] == hhr_pkg::TAG_TOMB) begin
				if (tomb < 0) tomb = pos;
			end else if (tbl_key[pos] == k) begin
				return pos;
			end
			pos = (pos + 1) % 64;
		end
		return tomb;
	endfunction

	function automatic answer_t registry_apply(input hhr_pkg::action_t a,
			input logic [63:0] k, input logic [3:0] t);
		answer_t r;
		int s;
		logic hit;
		r = '{hhr_pkg::ST_OK, 6'd0, 4'd0, 7'd0};
		if (a == hhr_pkg::ACT_CLEAR) begin
			foreach (tbl_tag[i]) tbl_tag[i] = hhr_pkg::TAG_EMPTY;
			live_n = 0;
		end else if (k == '0 || k == '1) begin
			r.st = hhr_pkg::ST_INVALID;
		end else begin
			s = find_slot(k);
			hit = s >= 0 && tbl_tag[s] == hhr_pkg::TAG_LIVE && tbl_key[s] == k;
			if (a == hhr_pkg::ACT_INSERT) begin
				if (s < 0) begin
					r.st = hhr_pkg::ST_FULL;
				end else begin
					if (!hit) begin
						live_n++;
						tbl_tag[s] = hhr_pkg::TAG_LIVE;
						tbl_key[s] = k;
					end
					tbl_type[s] = t;
					r.si = s[5:0];
					r.to = t;
				end
			end else if (!hit) begin
				r.st = hhr_pkg::ST_NOT_FOUND;
			end else begin
				r.si = s[5:0];
				r.to = tbl_type[s];
				if (a == hhr_pkg::ACT_DELETE) begin
					tbl_tag[s] = hhr_pkg::TAG_TOMB;
					live_n--;
				end
			end
		end
		r.lc = live_n[6:0];
		return r;
	endfunction

	task automatic send_word(input hhr_pkg::action_t a, input logic [63:0] k,
			input logic [3:0] t);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		action <= a;
		key <= k;
		handle_type <= t;
		in_valid <= 1'b1;
		pending.push_back(registry_apply(a, k, t));
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$error("result word with no expectation");
				errors++;
			end else begin
				e = pending.pop_front();
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					errors++;
				end
				if (slot_index !== e.si) begin
					$error("slot_index exp %0d got %0d", e.si, slot_index);
					errors++;
				end
				if (type_out !== e.to) begin
					$error("type_out exp %0d got %0d", e.to, type_out);
					errors++;
				end
				if (live_count !== e.lc) begin
					$error("live_count exp %0d got %0d", e.lc, live_count);
					errors++;
				end
			end
		end
	end

	function automatic row_t fixed(input hhr_pkg::action_t a, input logic [63:0] k,
			input logic [3:0] t, input hhr_pkg::status_t s, input logic [6:0] lc);
		return '{a, k, t, 1'b1, s, 6'd0, 4'd0, lc};
	endfunction

	function automatic row_t free(input hhr_pkg::action_t a, input logic [63:0] k,
			input logic [3:0] t);
		return '{a, k, t, 1'b0, hhr_pkg::ST_OK, 6'd0, 4'd0, 7'd0};
	endfunction

	task automatic random_phase(input int n, input int si, input int rs);
		hhr_pkg::action_t a;
		logic [63:0] k;
		int p;
		send_idle = si;
		recv_stall = rs;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			a = (p < 45) ? hhr_pkg::ACT_INSERT
				: (p < 70) ? hhr_pkg::ACT_LOOKUP
				: (p < 97) ? hhr_pkg::ACT_DELETE : hhr_pkg::ACT_CLEAR;
			p = $urandom_range(99);
			if (p < 3) k = '0;
			else if (p < 6) k = '1;
			else if (p < 15) k = {$urandom, $urandom};
			else k = key_pool[$urandom_range(15)] ^ 64'($urandom_range(7));
			send_word(a, k, 4'($urandom_range(15)));
		end
	endtask

	initial begin
		row_t dir [$];
		answer_t e;
		foreach (tbl_tag[i]) tbl_tag[i] = hhr_pkg::TAG_EMPTY;
		live_n = 0;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom} & ~64'h7 | 64'h8;
		dir.push_back(fixed(hhr_pkg::ACT_LOOKUP, 64'h1234, 4'd0, hhr_pkg::ST_NOT_FOUND, 7'd0));
		dir.push_back(fixed(hhr_pkg::ACT_INSERT, 64'h0, 4'hf, hhr_pkg::ST_INVALID, 7'd0));
		dir.push_back(fixed(hhr_pkg::ACT_INSERT, '1, 4'hf, hhr_pkg::ST_INVALID, 7'd0));
		dir.push_back(fixed(hhr_pkg::ACT_LOOKUP, '1, 4'h0, hhr_pkg::ST_INVALID, 7'd0));
		dir.push_back(fixed(hhr_pkg::ACT_DELETE, 64'h0, 4'h0, hhr_pkg::ST_INVALID, 7'd0));
		dir.push_back(free(hhr_pkg::ACT_INSERT, 64'h1, 4'hf));
		dir.push_back(free(hhr_pkg::ACT_INSERT, 64'hfffffffffffffffe, 4'h0));
		dir.push_back(free(hhr_pkg::ACT_INSERT, 64'h1, 4'h5));
		dir.push_back(free(hhr_pkg::ACT_LOOKUP, 64'h1, 4'h0));
		dir.push_back(free(hhr_pkg::ACT_DELETE, 64'h1, 4'h0));
		dir.push_back(fixed(hhr_pkg::ACT_DELETE, 64'h1, 4'h0, hhr_pkg::ST_NOT_FOUND, 7'd1));
		dir.push_back(free(hhr_pkg::ACT_INSERT, 64'h8000000000000000, 4'ha));
		dir.push_back(fixed(hhr_pkg::ACT_CLEAR, 64'h55, 4'h3, hhr_pkg::ST_OK, 7'd0));
		for (int i = 1; i <= 64; i++)
			dir.push_back(free(hhr_pkg::ACT_INSERT, 64'(i * 977), 4'(i)));
		dir.push_back(fixed(hhr_pkg::ACT_INSERT, 64'h7fffffffffffffff, 4'h1,
			hhr_pkg::ST_FULL, 7'd64));
		dir.push_back(free(hhr_pkg::ACT_DELETE, 64'(5 * 977), 4'h0));
		dir.push_back(free(hhr_pkg::ACT_INSERT, 64'h7fffffffffffffff, 4'h2));
		dir.push_back(fixed(hhr_pkg::ACT_CLEAR, 64'h0, 4'h0, hhr_pkg::ST_OK, 7'd0));
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (dir[i]) begin
			send_word(dir[i].act, dir[i].k, dir[i].ht);
			if (dir[i].known) begin
				e = '{dir[i].st, dir[i].si, dir[i].to, dir[i].lc};
				if (pending[$] !== e) begin
					$error("table row %0d exp %h model %h", i, e, pending[$]);
					errors++;
				end
			end
		end
		random_phase(400, 0, 0);
		random_phase(400, 72, 0);
		random_phase(400, 0, 72);
		random_phase(300, 14, 14);
		send_idle = 0;
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("** handle_hash_registry_core: PASSED **");
		else
			$display("** handle_hash_registry_core: FAILED **");
		$finish;
	end
endmodule
